>>> sv/sfdt_pkg.sv
package sfdt_pkg;

  // SMB header magic words, byte zero in the top byte
  localparam logic [31:0] MAGIC_V1 = 32'hFF53_4D42;
  localparam logic [31:0] MAGIC_V2 = 32'hFE53_4D42;

  // Configuration register indexes
  localparam logic CFG_DIRECT_PORT  = 1'b0;
  localparam logic CFG_NETBIOS_PORT = 1'b1;

  localparam logic [15:0] DIRECT_PORT_RESET  = 16'd445;
  localparam logic [15:0] NETBIOS_PORT_RESET = 16'd139;

  // Recorded dialect codes
  localparam logic DIALECT_SMB1 = 1'b0;
  localparam logic DIALECT_SMB2 = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_REJECT
  } state_t;

  // One flow table entry
  typedef struct packed {
    logic [31:0] client_addr;
    logic [31:0] server_addr;
    logic [15:0] svc_port;
    logic [31:0] open_time;
    logic [31:0] touch_time;
    logic [31:0] count;
    logic        dialect;
  } entry_t;

endpackage

>>> sv/sfdt_ram.sv
module sfdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/smb_flow_dialect_tracker.sv
// SMB flow tracker: records SMB client/server flows seen in TCP segments.
// Request channel: present the segment fields and raise start; the request
// is taken at a rising edge where start is high and busy is low.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 direct port,
// 1 NetBIOS port) and cfg_data; cfg_ready is always high. Write only idle.
// Result: one per request, shown for exactly one cycle with done high.
// Rejected requests (no server port, no magic, short payload) report all
// zeros from the result registers after one pass through the reject state.
// Accepted requests walk the flow table in one pass through a single RAM
// read port, one entry per cycle, comparing the flow key and tracking the
// oldest last-seen time with separate comparators; a match ends the walk
// early. busy falls in the cycle done is shown, so a new request can be
// taken then.
// The receiver cannot stall: done is a one-cycle strobe.
// Reset empties the table (occupancy zero) and restores ports 445 and 139.
module smb_flow_dialect_tracker #(
  parameter int SESSIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_address,
  input  logic [15:0] source_port,
  input  logic [31:0] dest_address,
  input  logic [15:0] dest_port,
  input  logic [63:0] payload_head,
  input  logic [15:0] payload_length,
  input  logic [31:0] timestamp,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // result channel
  output logic        done,
  output logic        accepted,
  output logic [3:0]  slot_index,
  output logic        new_flow,
  output logic        evicted,
  output logic        flow_dialect,
  output logic [31:0] flow_count,
  output logic [31:0] flow_first_seen
);

  localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int OCC_W = $clog2(SESSIONS + 1);
  localparam int ENT_W = $bits(sfdt_pkg::entry_t);

  sfdt_pkg::state_t state, state_next;

  logic [15:0]      direct_port;
  logic [15:0]      netbios_port;
  logic [OCC_W-1:0] occupancy;

  // latched request
  logic [31:0] caddr;
  logic [31:0] vaddr;
  logic [15:0] vport;
  logic [31:0] now;
  logic        dia;

  // scan state
  logic [OCC_W-1:0] issue_cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] match_idx;
  sfdt_pkg::entry_t ent;
  logic [31:0]      min_last;
  logic [IDX_W-1:0] min_idx;

  // memory port
  logic             rd_en;
  logic             wr_en;
  logic [ENT_W-1:0] rd_word;
  sfdt_pkg::entry_t rd_ent;
  sfdt_pkg::entry_t wr_ent;
  logic [IDX_W-1:0] slot;

  // front-end decode
  logic        take;
  logic        dst_srv;
  logic        src_srv;
  logic        srv_ok;
  logic [31:0] head_hi;
  logic [31:0] head_lo;
  logic        magic_ok;
  logic        magic_dia;

  // scan compare
  logic hit;
  logic last_cmp;
  logic issue;
  logic full;
  sfdt_pkg::entry_t base;
  logic [IDX_W+3:0] slot_wide;

  assign busy      = (state != sfdt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  // Pick the server side, destination first
  assign dst_srv = (dest_port == direct_port) || (dest_port == netbios_port);
  assign src_srv = (source_port == direct_port) || (source_port == netbios_port);
  assign srv_ok  = dst_srv || src_srv;

  // Look for the magic, bare or behind a NetBIOS session header
  assign head_hi = payload_head[63:32];
  assign head_lo = payload_head[31:0];

  always_comb begin
    magic_ok  = 1'b0;
    magic_dia = sfdt_pkg::DIALECT_SMB1;
    if (payload_length >= 16'd4) begin
      priority if (head_hi == sfdt_pkg::MAGIC_V1) begin
        magic_ok = 1'b1;
      end else if (head_hi == sfdt_pkg::MAGIC_V2) begin
        magic_ok  = 1'b1;
        magic_dia = sfdt_pkg::DIALECT_SMB2;
      end else if (payload_length >= 16'd8 && head_hi[31:24] == 8'h00) begin
        if (head_lo == sfdt_pkg::MAGIC_V1) begin
          magic_ok = 1'b1;
        end else if (head_lo == sfdt_pkg::MAGIC_V2) begin
          magic_ok  = 1'b1;
          magic_dia = sfdt_pkg::DIALECT_SMB2;
        end
      end else begin
        magic_ok = 1'b0;
      end
    end
  end

  // Compare the entry returned by the RAM
  assign rd_ent   = sfdt_pkg::entry_t'(rd_word);
  assign hit      = cmp_vld && (rd_ent.svc_port == vport) &&
                    (rd_ent.client_addr == caddr) && (rd_ent.server_addr == vaddr);
  assign last_cmp = cmp_vld && (OCC_W'(cmp_idx) == occupancy - OCC_W'(1));
  assign full     = (occupancy == OCC_W'(SESSIONS));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sfdt_pkg::ST_IDLE: begin
        if (take) begin
          if (!(srv_ok && magic_ok)) begin
            state_next = sfdt_pkg::ST_REJECT;
          end else if (occupancy == '0) begin
            state_next = sfdt_pkg::ST_RESOLVE;
          end else begin
            state_next = sfdt_pkg::ST_SCAN;
          end
        end
      end
      sfdt_pkg::ST_SCAN: begin
        if (hit || last_cmp) begin
          state_next = sfdt_pkg::ST_RESOLVE;
        end
      end
      sfdt_pkg::ST_RESOLVE: state_next = sfdt_pkg::ST_IDLE;
      sfdt_pkg::ST_REJECT:  state_next = sfdt_pkg::ST_IDLE;
      default:              state_next = sfdt_pkg::ST_IDLE;
    endcase
  end

  // Memory control: issue reads during the walk, write back on resolve
  always_comb begin
    issue = 1'b0;
    wr_en = 1'b0;
    unique case (state)
      sfdt_pkg::ST_SCAN:    issue = (issue_cnt < occupancy) && !hit;
      sfdt_pkg::ST_RESOLVE: wr_en = 1'b1;
      default: begin
        issue = 1'b0;
        wr_en = 1'b0;
      end
    endcase
    rd_en = issue;
  end

  // Choose the slot and build the updated entry
  always_comb begin
    if (found) begin
      slot = match_idx;
    end else if (full) begin
      slot = min_idx;
    end else begin
      slot = issue_cnt[IDX_W-1:0];
    end

    if (found) begin
      base = ent;
    end else begin
      base.client_addr = caddr;
      base.server_addr = vaddr;
      base.svc_port    = vport;
      base.open_time   = now;
      base.touch_time  = now;
      base.count       = '0;
      base.dialect     = dia;
    end

    wr_ent            = base;
    wr_ent.touch_time = now;
    wr_ent.count      = (base.count == '1) ? base.count : base.count + 32'd1;
    wr_ent.dialect    = (base.dialect != sfdt_pkg::DIALECT_SMB1) ? dia
                                                                 : sfdt_pkg::DIALECT_SMB1;
    slot_wide         = {4'b0000, slot};
  end

  sfdt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SESSIONS)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(slot),
    .wdata(wr_ent),
    .re   (rd_en),
    .raddr(issue_cnt[IDX_W-1:0]),
    .rdata(rd_word)
  );

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sfdt_pkg::ST_IDLE;
      direct_port  <= sfdt_pkg::DIRECT_PORT_RESET;
      netbios_port <= sfdt_pkg::NETBIOS_PORT_RESET;
      occupancy    <= '0;
      cmp_vld      <= 1'b0;
      done         <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= issue;
      done    <= (state == sfdt_pkg::ST_RESOLVE) || (state == sfdt_pkg::ST_REJECT);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sfdt_pkg::CFG_DIRECT_PORT:  direct_port  <= cfg_data;
          sfdt_pkg::CFG_NETBIOS_PORT: netbios_port <= cfg_data;
          default:                    direct_port  <= direct_port;
        endcase
      end
      if (state == sfdt_pkg::ST_RESOLVE && !found && !full) begin
        occupancy <= occupancy + OCC_W'(1);
      end
    end
  end

  // Latch the request and track the walk
  always_ff @(posedge clk) begin
    if (take) begin
      if (dst_srv) begin
        vport <= dest_port;
        vaddr <= dest_address;
        caddr <= source_address;
      end else begin
        vport <= source_port;
        vaddr <= source_address;
        caddr <= dest_address;
      end
      now       <= timestamp;
      dia       <= magic_dia;
      issue_cnt <= '0;
      found     <= 1'b0;
    end else begin
      if (issue) begin
        issue_cnt <= issue_cnt + OCC_W'(1);
      end
      if (hit) begin
        found     <= 1'b1;
        match_idx <= cmp_idx;
        ent       <= rd_ent;
      end
    end
    if (issue) begin
      cmp_idx <= issue_cnt[IDX_W-1:0];
    end
    // Hold the oldest last-seen time, lowest index on ties
    if (cmp_vld && (cmp_idx == '0 || rd_ent.touch_time < min_last)) begin
      min_last <= rd_ent.touch_time;
      min_idx  <= cmp_idx;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state == sfdt_pkg::ST_RESOLVE) begin
      accepted        <= 1'b1;
      slot_index      <= slot_wide[3:0];
      new_flow        <= !found;
      evicted         <= !found && full;
      flow_dialect    <= wr_ent.dialect;
      flow_count      <= wr_ent.count;
      flow_first_seen <= wr_ent.open_time;
    end else if (state == sfdt_pkg::ST_REJECT) begin
      accepted        <= 1'b0;
      slot_index      <= '0;
      new_flow        <= 1'b0;
      evicted         <= 1'b0;
      flow_dialect    <= 1'b0;
      flow_count      <= '0;
      flow_first_seen <= '0;
    end
  end

endmodule

>>> tb/smb_flow_dialect_tracker_test.sv
module smb_flow_dialect_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SESSIONS      = 16;
  localparam int SETTLE_CYCLES = SESSIONS + 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int CLIENTS       = 24;
  localparam int SERVERS       = 3;

  localparam logic [31:0] CLIENT_A = 32'h0A00_0001;
  localparam logic [31:0] SERVER_S = 32'hC0A8_0001;

  typedef struct packed {
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic [63:0] payload_head;
    logic [15:0] payload_length;
    logic [31:0] timestamp;
  } segment_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  slot_index;
    logic        new_flow;
    logic        evicted;
    logic        flow_dialect;
    logic [31:0] flow_count;
    logic [31:0] flow_first_seen;
  } flow_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] source_address = '0;
  logic [15:0] source_port = '0;
  logic [31:0] dest_address = '0;
  logic [15:0] dest_port = '0;
  logic [63:0] payload_head = '0;
  logic [15:0] payload_length = '0;
  logic [31:0] timestamp = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = sfdt_pkg::CFG_DIRECT_PORT;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic        accepted;
  logic [3:0]  slot_index;
  logic        new_flow;
  logic        evicted;
  logic        flow_dialect;
  logic [31:0] flow_count;
  logic [31:0] flow_first_seen;

  // Flow table mirror and port settings
  logic [15:0]      direct_port_cfg = sfdt_pkg::DIRECT_PORT_RESET;
  logic [15:0]      netbios_port_cfg = sfdt_pkg::NETBIOS_PORT_RESET;
  sfdt_pkg::entry_t flow_table [SESSIONS];
  int               flows_in_table = 0;
  flow_result_t     pending_results [$];

  int          error_count = 0;
  int          stall_cycles = 0;
  int          idle_max = 16;
  logic [31:0] wall_clock = 32'd1000;
  logic [31:0] client_pool [CLIENTS];
  logic [31:0] server_pool [SERVERS];

  smb_flow_dialect_tracker #(
    .SESSIONS(SESSIONS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .source_address (source_address),
    .source_port    (source_port),
    .dest_address   (dest_address),
    .dest_port      (dest_port),
    .payload_head   (payload_head),
    .payload_length (payload_length),
    .timestamp      (timestamp),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .accepted       (accepted),
    .slot_index     (slot_index),
    .new_flow       (new_flow),
    .evicted        (evicted),
    .flow_dialect   (flow_dialect),
    .flow_count     (flow_count),
    .flow_first_seen(flow_first_seen)
  );

  always #4 clk = ~clk;

  // Record one segment in the mirror table and return the expected result
  function automatic flow_result_t track_segment(segment_t s);
    flow_result_t r;
    logic [31:0]  client;
    logic [31:0]  server;
    logic [15:0]  port;
    logic [31:0]  hi;
    logic [31:0]  lo;
    logic         dialect;
    bit           is_smb;
    bit           found;
    int           slot;
    r = '0;
    hi = s.payload_head[63:32];
    lo = s.payload_head[31:0];
    // pick the server side, destination first
    if (s.dest_port == direct_port_cfg || s.dest_port == netbios_port_cfg) begin
      port = s.dest_port;
      server = s.dest_address;
      client = s.source_address;
    end else if (s.source_port == direct_port_cfg || s.source_port == netbios_port_cfg) begin
      port = s.source_port;
      server = s.source_address;
      client = s.dest_address;
    end else begin
      return r;
    end
    // bare magic first, then magic behind a session header
    is_smb = 1'b1;
    dialect = sfdt_pkg::DIALECT_SMB1;
    if (s.payload_length < 16'd4) is_smb = 1'b0;
    else if (hi == sfdt_pkg::MAGIC_V1) dialect = sfdt_pkg::DIALECT_SMB1;
    else if (hi == sfdt_pkg::MAGIC_V2) dialect = sfdt_pkg::DIALECT_SMB2;
    else if (s.payload_length >= 16'd8 && hi[31:24] == 8'h00 && lo == sfdt_pkg::MAGIC_V1)
      dialect = sfdt_pkg::DIALECT_SMB1;
    else if (s.payload_length >= 16'd8 && hi[31:24] == 8'h00 && lo == sfdt_pkg::MAGIC_V2)
      dialect = sfdt_pkg::DIALECT_SMB2;
    else is_smb = 1'b0;
    if (!is_smb) return r;
    // find the flow among the occupied slots
    found = 1'b0;
    slot = 0;
    for (int i = 0; i < flows_in_table; i++) begin
      if (!found && flow_table[i].svc_port == port && flow_table[i].client_addr == client &&
          flow_table[i].server_addr == server) begin
        slot = i;
        found = 1'b1;
      end
    end
    // allocate a free slot, or take the one seen longest ago
    if (!found) begin
      r.new_flow = 1'b1;
      if (flows_in_table < SESSIONS) begin
        slot = flows_in_table;
        flows_in_table++;
      end else begin
        r.evicted = 1'b1;
        slot = 0;
        for (int i = 1; i < SESSIONS; i++)
          if (flow_table[i].touch_time < flow_table[slot].touch_time) slot = i;
      end
      flow_table[slot] = '{client_addr: client, server_addr: server, svc_port: port,
                           open_time: s.timestamp, touch_time: s.timestamp, count: '0,
                           dialect: dialect};
    end
    // update; once SMB1 the dialect holds
    flow_table[slot].touch_time = s.timestamp;
    if (flow_table[slot].count != '1) flow_table[slot].count = flow_table[slot].count + 1;
    if (flow_table[slot].dialect != sfdt_pkg::DIALECT_SMB1) flow_table[slot].dialect = dialect;
    r.accepted = 1'b1;
    r.slot_index = 4'(slot);
    r.flow_dialect = flow_table[slot].dialect;
    r.flow_count = flow_table[slot].count;
    r.flow_first_seen = flow_table[slot].open_time;
    return r;
  endfunction

  function automatic logic [63:0] smb_head(bit framed, logic dialect);
    logic [31:0] magic;
    magic = (dialect == sfdt_pkg::DIALECT_SMB2) ? sfdt_pkg::MAGIC_V2 : sfdt_pkg::MAGIC_V1;
    if (framed) return {8'h00, 24'($urandom), magic};
    return {magic, $urandom};
  endfunction

  function automatic segment_t flow_segment(logic [31:0] client, logic [31:0] server,
                                            logic [15:0] port, bit to_server,
                                            logic [63:0] head, logic [15:0] len,
                                            logic [31:0] stamp);
    segment_t s;
    s.payload_head = head;
    s.payload_length = len;
    s.timestamp = stamp;
    if (to_server) begin
      s.source_address = client;
      s.source_port = 16'($urandom);
      s.dest_address = server;
      s.dest_port = port;
    end else begin
      s.source_address = server;
      s.source_port = port;
      s.dest_address = client;
      s.dest_port = 16'($urandom);
    end
    return s;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Present one request after a random gap and hold it until taken
  task automatic send_segment(segment_t s);
    int gap;
    gap = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    source_address <= s.source_address;
    source_port <= s.source_port;
    dest_address <= s.dest_address;
    dest_port <= s.dest_port;
    payload_head <= s.payload_head;
    payload_length <= s.payload_length;
    timestamp <= s.timestamp;
    do @(posedge clk); while (busy);
    pending_results.push_back(track_segment(s));
  endtask

  // Drop start, wait for every result, then let the block settle
  task automatic end_requests();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_server_ports(logic [15:0] direct, logic [15:0] netbios);
    end_requests();
    cfg_valid <= 1'b1;
    cfg_index <= sfdt_pkg::CFG_DIRECT_PORT;
    cfg_data <= direct;
    do @(posedge clk); while (!cfg_ready);
    direct_port_cfg = direct;
    cfg_index <= sfdt_pkg::CFG_NETBIOS_PORT;
    cfg_data <= netbios;
    do @(posedge clk); while (!cfg_ready);
    netbios_port_cfg = netbios;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_magic_and_ports();
    segment_t s;
    // SMB1 at time zero opens slot 0; a later SMB2 request keeps it SMB1
    send_segment(flow_segment(CLIENT_A, SERVER_S, 16'd445, 1'b1,
                              smb_head(1'b0, sfdt_pkg::DIALECT_SMB1), 16'd64, 32'd0));
    send_segment(flow_segment(CLIENT_A, SERVER_S, 16'd445, 1'b0,
                              smb_head(1'b0, sfdt_pkg::DIALECT_SMB2), 16'd4, 32'd5));
    // framed SMB2 on the NetBIOS port, then an SMB1 request drops it to SMB1
    send_segment(flow_segment(CLIENT_A, SERVER_S, 16'd139, 1'b1,
                              smb_head(1'b1, sfdt_pkg::DIALECT_SMB2), 16'd8, 32'd6));
    send_segment(flow_segment(CLIENT_A, SERVER_S, 16'd139, 1'b0,
                              smb_head(1'b1, sfdt_pkg::DIALECT_SMB1), 16'd9, 32'd8));
    // rejects: short framed, short bare, no magic, nonzero session byte
    send_segment(flow_segment(CLIENT_A, SERVER_S, 16'd139, 1'b1,
                              smb_head(1'b1, sfdt_pkg::DIALECT_SMB2), 16'd7, 32'd9));
    send_segment(flow_segment(CLIENT_A, SERVER_S, 16'd445, 1'b1,
                              smb_head(1'b0, sfdt_pkg::DIALECT_SMB1), 16'd3, 32'd9));
    send_segment(flow_segment(CLIENT_A, SERVER_S, 16'd445, 1'b1,
                              64'h0000_0000_1234_5678, 16'd100, 32'd9));
    send_segment(flow_segment(CLIENT_A, SERVER_S, 16'd445, 1'b1,
                              {8'h85, 24'h0, sfdt_pkg::MAGIC_V1}, 16'd100, 32'd9));
    // no server port on either side
    s = flow_segment(CLIENT_A, SERVER_S, 16'd8080, 1'b1,
                     smb_head(1'b0, sfdt_pkg::DIALECT_SMB1), 16'd100, 32'd9);
    s.source_port = 16'd80;
    send_segment(s);
    // both ports are server ports: destination wins
    s = flow_segment(CLIENT_A, SERVER_S, 16'd445, 1'b1,
                     smb_head(1'b0, sfdt_pkg::DIALECT_SMB1), 16'd100, 32'd10);
    s.source_port = 16'd139;
    send_segment(s);
    // extreme field values
    send_segment(flow_segment(32'hFFFF_FFFF, 32'h0, 16'd445, 1'b1,
                              smb_head(1'b0, sfdt_pkg::DIALECT_SMB2), 16'hFFFF,
                              32'hFFFF_FFFF));
    send_segment(flow_segment(32'h0, 32'hFFFF_FFFF, 16'd139, 1'b0,
                              {sfdt_pkg::MAGIC_V1, 32'hFFFF_FFFF}, 16'hFFFF, 32'h0));
  endtask

  task automatic test_table_eviction();
    // fill the remaining slots with one shared last-seen time
    for (int i = 0; i < 12; i++)
      send_segment(flow_segment(32'h0B00_0000 + i, SERVER_S, 16'd445, 1'b1,
                                smb_head(i[0], (i % 3 == 0) ? sfdt_pkg::DIALECT_SMB2
                                                            : sfdt_pkg::DIALECT_SMB1),
                                16'd64, 32'd20));
    // each new flow now replaces the oldest entry, lowest slot on ties
    for (int i = 0; i < 4; i++)
      send_segment(flow_segment(32'h0C00_0000 + i, SERVER_S, 16'd139, i[0],
                                smb_head(1'b0, sfdt_pkg::DIALECT_SMB2), 16'd64,
                                32'd30 + i));
  endtask

  task automatic test_random_traffic(int items);
    segment_t    s;
    logic [31:0] client;
    logic [15:0] port;
    bit          framed;
    int          mutation;
    for (int k = 0; k < items; k++) begin
      // alternate bursts with no gaps and stretches with random gaps
      if (k % 40 == 0) idle_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
      wall_clock = wall_clock + $urandom_range(0, 2);
      // well-formed request on a pooled flow, a few clients much hotter than the rest
      client = $urandom_range(0, 1) ? client_pool[$urandom_range(0, 7)]
                                    : client_pool[$urandom_range(0, CLIENTS - 1)];
      port = $urandom_range(0, 1) ? direct_port_cfg : netbios_port_cfg;
      framed = 1'($urandom_range(0, 1));
      s = flow_segment(client, server_pool[$urandom_range(0, SERVERS - 1)], port,
                       1'($urandom_range(0, 1)), smb_head(framed, 1'($urandom_range(0, 1))),
                       (!framed && $urandom_range(0, 3) == 0) ? 16'($urandom_range(4, 7))
                                                              : 16'($urandom_range(8, 65535)),
                       wall_clock);
      // break or scramble some of them
      mutation = $urandom_range(0, 99);
      if (mutation < 10) begin
        s.payload_length = 16'($urandom_range(0, 7));
      end else if (mutation < 18) begin
        s.payload_head = {$urandom, $urandom};
      end else if (mutation < 28) begin
        s.source_address = $urandom;
        s.source_port = 16'($urandom);
        s.dest_address = $urandom;
        s.dest_port = 16'($urandom);
        s.payload_head = {$urandom, $urandom};
        s.payload_length = 16'($urandom);
      end else if (mutation < 38) begin
        s.source_address = $urandom;
        s.dest_address = $urandom;
      end
      if ($urandom_range(0, 19) == 0) s.timestamp = $urandom;
      send_segment(s);
    end
  endtask

  // Compare each result with the oldest pending expectation
  always @(posedge clk) begin
    flow_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual accepted %0b",
                 $time, accepted);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(accepted));
        check_field("slot_index", 32'(want.slot_index), 32'(slot_index));
        check_field("new_flow", 32'(want.new_flow), 32'(new_flow));
        check_field("evicted", 32'(want.evicted), 32'(evicted));
        check_field("flow_dialect", 32'(want.flow_dialect), 32'(flow_dialect));
        check_field("flow_count", want.flow_count, flow_count);
        check_field("flow_first_seen", want.flow_first_seen, flow_first_seen);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CLIENTS; i++) client_pool[i] = $urandom;
    for (int i = 0; i < SERVERS; i++) server_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_magic_and_ports();
    test_table_eviction();
    test_random_traffic(260);
    set_server_ports(16'h0000, 16'hFFFF);
    test_random_traffic(260);
    set_server_ports(16'hFFFF, 16'h0000);
    test_random_traffic(260);
    set_server_ports(16'd8445, 16'd8445);
    test_random_traffic(260);
    set_server_ports(16'($urandom), 16'($urandom));
    test_random_traffic(260);

    end_requests();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
